@@ rtl/yjk_pkg.sv @@
// Package for the YJK/YAE pixel decoder: shared types and constants.
// No dependencies. Used by yjk_pixel_conv and the core top level.
`timescale 1ns / 1ps
`default_nettype none

package yjk_pkg;

    // Signed 6-bit chroma value (J or K)
    typedef logic signed [5:0] chroma_t;

    // One decoded pixel: palette flag and colour / palette index
    typedef struct packed {
        logic        is_palette;
        logic [14:0] value;
    } pix_res_t;

    localparam int unsigned PIX_PER_GROUP = 4;
    // Bit of a VRAM byte that marks a palette pixel in YAE mode
    localparam int unsigned YAE_MARK_BIT  = 3;
    localparam logic [4:0]  CLAMP_MAX     = 5'd31;

endpackage

`default_nettype wire

@@ rtl/yjk_pixel_conv.sv @@
// Per-pixel converter: Y plus shared J/K to RGB555, or YAE palette index.
// Pure combinational logic. Depends on yjk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yjk_pixel_conv (
    input  wire logic [7:0]       pix_byte,
    input  wire yjk_pkg::chroma_t j_val,
    input  wire yjk_pkg::chroma_t k_val,
    input  wire logic             yae_enable,
    output yjk_pkg::pix_res_t     pix_res
);

    logic [4:0]        y;
    logic signed [7:0] r_sum;
    logic signed [7:0] g_sum;
    logic signed [9:0] b_num;
    logic [4:0]        r_val;
    logic [4:0]        g_val;
    logic [4:0]        b_val;

    assign y = pix_byte[7:3];

    assign r_sum = $signed({3'b000, y}) + $signed({{2{j_val[5]}}, j_val});
    assign g_sum = $signed({3'b000, y}) + $signed({{2{k_val[5]}}, k_val});

    // 5Y - 2J - K + 2, range -91..253
    assign b_num = $signed({3'b000, y, 2'b00}) + $signed({5'b00000, y})
                 - $signed({{3{j_val[5]}}, j_val, 1'b0})
                 - $signed({{4{k_val[5]}}, k_val})
                 + 10'sd2;

    always_comb begin
        if (r_sum[7]) begin
            r_val = 5'd0;
        end else if (r_sum[6:5] != 2'b00) begin
            r_val = yjk_pkg::CLAMP_MAX;
        end else begin
            r_val = r_sum[4:0];
        end

        if (g_sum[7]) begin
            g_val = 5'd0;
        end else if (g_sum[6:5] != 2'b00) begin
            g_val = yjk_pkg::CLAMP_MAX;
        end else begin
            g_val = g_sum[4:0];
        end

        // Divide by four as a shift; a negative numerator clamps to zero
        if (b_num[9]) begin
            b_val = 5'd0;
        end else if (b_num[8:7] != 2'b00) begin
            b_val = yjk_pkg::CLAMP_MAX;
        end else begin
            b_val = b_num[6:2];
        end

        if (yae_enable && pix_byte[yjk_pkg::YAE_MARK_BIT]) begin
            pix_res.is_palette = 1'b1;
            pix_res.value      = {11'd0, pix_byte[7:4]};
        end else begin
            pix_res.is_palette = 1'b0;
            pix_res.value      = {r_val, g_val, b_val};
        end
    end

endmodule

`default_nettype wire

@@ rtl/yjk_yae_pixel_decoder_core.sv @@
// YJK/YAE pixel decoder core: four VRAM bytes in, four RGB555 / palette pixels out.
// An accepted item passes the input register, then the result register, on its way to m_valid.
// Throughput: one four-pixel group per cycle while m_ready stays high; set by the single conversion stage.
// Reset (aresetn, synchronous, active low) empties both stages and clears yae_enable.
// Depends on yjk_pkg and yjk_pixel_conv.
`timescale 1ns / 1ps
`default_nettype none

module yjk_yae_pixel_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: YAE mode enable
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,

    // Input channel: one four-pixel group per item
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,

    // Result channel: four decoded pixels per item
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_pix0_is_palette,
    output logic [14:0]      m_pix0_value,
    output logic             m_pix1_is_palette,
    output logic [14:0]      m_pix1_value,
    output logic             m_pix2_is_palette,
    output logic [14:0]      m_pix2_value,
    output logic             m_pix3_is_palette,
    output logic [14:0]      m_pix3_value
);

    localparam int unsigned NPIX = yjk_pkg::PIX_PER_GROUP;

    // Configuration register
    logic yae_enable_reg;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg [NPIX];

    // Result stage
    logic              out_valid_reg;
    yjk_pkg::pix_res_t out_pix_reg [NPIX];

    // Conversion results
    yjk_pkg::pix_res_t pix_next [NPIX];
    yjk_pkg::chroma_t  k_val;
    yjk_pkg::chroma_t  j_val;

    logic in_advance;
    logic s_accept;

    // The result register frees up when empty or when its item is taken;
    // the input register frees up when empty or when it moves forward.
    assign in_advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || !out_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yae_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            yae_enable_reg <= cfg_wr_data;
        end
    end

    // Input register: advance on accept, drop when moved out with nothing new
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg[0] <= s_byte0;
            in_byte_reg[1] <= s_byte1;
            in_byte_reg[2] <= s_byte2;
            in_byte_reg[3] <= s_byte3;
        end
    end

    // Chroma: low three bits of the first byte, two bits plus sign of the second
    assign k_val = $signed({in_byte_reg[1][2:0], in_byte_reg[0][2:0]});
    assign j_val = $signed({in_byte_reg[3][2:0], in_byte_reg[2][2:0]});

    for (genvar gi = 0; gi < NPIX; gi++) begin : g_pix
        yjk_pixel_conv u_conv (
            .pix_byte   (in_byte_reg[gi]),
            .j_val      (j_val),
            .k_val      (k_val),
            .yae_enable (yae_enable_reg),
            .pix_res    (pix_next[gi])
        );
    end

    // Result register: hold while stalled, load when the input stage advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            for (int i = 0; i < NPIX; i++) begin
                out_pix_reg[i] <= pix_next[i];
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pix0_is_palette = out_pix_reg[0].is_palette;
    assign m_pix0_value      = out_pix_reg[0].value;
    assign m_pix1_is_palette = out_pix_reg[1].is_palette;
    assign m_pix1_value      = out_pix_reg[1].value;
    assign m_pix2_is_palette = out_pix_reg[2].is_palette;
    assign m_pix2_value      = out_pix_reg[2].value;
    assign m_pix3_is_palette = out_pix_reg[3].is_palette;
    assign m_pix3_value      = out_pix_reg[3].value;

    // An empty input stage always takes a new item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("s_ready low with empty input stage");

    // A new result only appears after the input stage held an item
    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");

    // Palette pixels only come out in YAE mode and carry a 4-bit index
    a_palette_pix0: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pix_reg[0].is_palette)
            |-> (yae_enable_reg && out_pix_reg[0].value[14:4] == 11'd0))
        else $error("bad palette result on pixel 0");

    a_palette_pix3: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pix_reg[3].is_palette)
            |-> (yae_enable_reg && out_pix_reg[3].value[14:4] == 11'd0))
        else $error("bad palette result on pixel 3");

endmodule

`default_nettype wire

@@ dv/yjk_yae_pixel_decoder_checker.sv @@
// Scoreboard for the YJK/YAE pixel decoder core: decodes every accepted group itself
// and compares the four pixels of each result. Depends on yjk_pkg.
`timescale 1ns / 1ps

module yjk_yae_pixel_decoder_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_pix0_is_palette,
    input  wire logic [14:0] m_pix0_value,
    input  wire logic        m_pix1_is_palette,
    input  wire logic [14:0] m_pix1_value,
    input  wire logic        m_pix2_is_palette,
    input  wire logic [14:0] m_pix2_value,
    input  wire logic        m_pix3_is_palette,
    input  wire logic [14:0] m_pix3_value,
    output int               fail_count,
    output int               outstanding
);

    typedef yjk_pkg::pix_res_t [yjk_pkg::PIX_PER_GROUP-1:0] group_res_t;

    logic       yae_mode;
    group_res_t expected_groups[$];
    group_res_t got;
    group_res_t want;
    int         n;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        yae_mode    = 1'b0;
    end

    function automatic int chroma_value(logic [7:0] lo, logic [7:0] hi);
        int v;
        v = int'(lo[2:0]) + 8 * int'(hi[1:0]);
        if (hi[2]) begin
            v -= 32;
        end
        return v;
    endfunction

    function automatic int clamp_channel(int v);
        if (v < 0) begin
            return 0;
        end
        if (v > int'(yjk_pkg::CLAMP_MAX)) begin
            return int'(yjk_pkg::CLAMP_MAX);
        end
        return v;
    endfunction

    function automatic logic [14:0] yjk_to_rgb555(int y, int j, int k);
        int r;
        int g;
        int b;
        int num;
        r   = clamp_channel(y + j);
        g   = clamp_channel(y + k);
        num = 5 * y - 2 * j - k + 2;
        // a negative numerator truncates to zero or below, so blue is dark
        b   = (num < 0) ? 0 : clamp_channel(num / 4);
        return {r[4:0], g[4:0], b[4:0]};
    endfunction

    function automatic group_res_t decode_group(logic [3:0][7:0] grp, logic yae_on);
        group_res_t res;
        int         j;
        int         k;
        k = chroma_value(grp[0], grp[1]);
        j = chroma_value(grp[2], grp[3]);
        for (int p = 0; p < yjk_pkg::PIX_PER_GROUP; p++) begin
            if (yae_on && grp[p][yjk_pkg::YAE_MARK_BIT]) begin
                res[p].is_palette = 1'b1;
                res[p].value      = 15'(grp[p][7:4]);
            end else begin
                res[p].is_palette = 1'b0;
                res[p].value      = yjk_to_rgb555(int'(grp[p][7:3]), j, k);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got_v, want_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            yae_mode = 1'b0;
            expected_groups.delete();
        end else begin
            if (m_valid && m_ready) begin
                got[0] = {m_pix0_is_palette, m_pix0_value};
                got[1] = {m_pix1_is_palette, m_pix1_value};
                got[2] = {m_pix2_is_palette, m_pix2_value};
                got[3] = {m_pix3_is_palette, m_pix3_value};
                if (expected_groups.size() == 0) begin
                    report_mismatch("result with no group pending", got[0], 0);
                end else begin
                    want = expected_groups.pop_front();
                    for (n = 0; n < yjk_pkg::PIX_PER_GROUP; n++) begin
                        if (got[n].is_palette !== want[n].is_palette) begin
                            report_mismatch($sformatf("pix%0d_is_palette", n),
                                            got[n].is_palette, want[n].is_palette);
                        end
                        if (got[n].value !== want[n].value) begin
                            report_mismatch($sformatf("pix%0d_value", n),
                                            got[n].value, want[n].value);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_groups.push_back(
                    decode_group({s_byte3, s_byte2, s_byte1, s_byte0}, yae_mode));
            end
            if (cfg_wr_en) begin
                yae_mode = cfg_wr_data;
            end
        end
        outstanding <= expected_groups.size();
    end

endmodule

@@ dv/yjk_yae_pixel_decoder_core_tb.sv @@
// Testbench top for the YJK/YAE pixel decoder core: drives groups, stalls both sides
// and gives the verdict. Depends on yjk_yae_pixel_decoder_core and the checker module.
`timescale 1ns / 1ps

module yjk_yae_pixel_decoder_core_tb;

    localparam int          DIRECTED_COUNT = 11;
    localparam int          RAND_PHASES    = 6;
    localparam int          PHASE_ITEMS    = 100;
    localparam int          LONG_HOLD      = 160;
    localparam int          TAIL_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_byte0     = 8'h00;
    logic [7:0]  s_byte1     = 8'h00;
    logic [7:0]  s_byte2     = 8'h00;
    logic [7:0]  s_byte3     = 8'h00;
    logic        m_ready     = 1'b0;
    wire logic   s_ready;
    wire logic   m_valid;
    wire logic        m_pix0_is_palette;
    wire logic [14:0] m_pix0_value;
    wire logic        m_pix1_is_palette;
    wire logic [14:0] m_pix1_value;
    wire logic        m_pix2_is_palette;
    wire logic [14:0] m_pix2_value;
    wire logic        m_pix3_is_palette;
    wire logic [14:0] m_pix3_value;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_cnt = 0;
    // calm: no idling on either side; hold_req: ask the receiver for one long hold-off
    logic        calm      = 1'b0;
    logic        hold_req  = 1'b0;

    yjk_yae_pixel_decoder_core u_top (.*);

    yjk_yae_pixel_decoder_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Directed groups, packed as {byte0, byte1, byte2, byte3}.
    function automatic logic [31:0] directed_group(int idx);
        case (idx)
            0:       return 32'h00_00_00_00; // black, zero chroma
            1:       return 32'hFF_FF_FF_FF; // all bits set, chroma -1
            2:       return 32'hFF_FB_FF_FB; // bright Y with J = K = +31: clamp red/green high
            3:       return 32'h07_03_07_03; // dark Y with J = K = +31: negative blue numerator
            4:       return 32'h00_04_00_04; // J = K = -32 with Y = 0: clamp red/green low
            5:       return 32'hF8_FC_F8_FC; // J = K = -32 with Y = 31: clamp blue high
            6:       return 32'h08_18_88_F8; // bit 3 on every byte, palette indexes 0/1/8/15
            7:       return 32'h0F_1B_77_EC;
            8:       return 32'hF0_E5_08_0B;
            9:       return 32'h5A_A5_3C_C3;
            default: return 32'h8F_7F_48_B6;
        endcase
    endfunction

    // Random bytes, now and then pinned to an edge value.
    function automatic logic [31:0] random_group();
        logic [31:0] grp;
        grp = $urandom();
        for (int p = 0; p < 4; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       grp[8*p +: 8] = 8'h00;
                    1:       grp[8*p +: 8] = 8'hFF;
                    2:       grp[8*p +: 8] = 8'h07;
                    default: grp[8*p +: 8] = 8'hF8;
                endcase
            end
        end
        return grp;
    endfunction

    // Offer one group and hold it until the block takes it.
    task automatic send_group(logic [31:0] grp);
        s_valid <= 1'b1;
        s_byte0 <= grp[31:24];
        s_byte1 <= grp[23:16];
        s_byte2 <= grp[15:8];
        s_byte3 <= grp[7:0];
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every pending result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    // Write the mode register; only called with the block empty.
    task automatic set_mode(logic yae_on);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= yae_on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int  ph;
        int  idx;
        logic phase_mode;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Run the directed groups in plain YJK mode, then again with YAE on.
        for (int mode = 0; mode < 2; mode++) begin
            if (mode != 0) begin
                set_mode(1'b1);
            end
            for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
                send_group(directed_group(idx));
                sender_gap();
            end
            drain();
        end

        // Random phases; switch the mode between them with the pipe empty.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                phase_mode = 1'b0;
            end else if (ph == 1) begin
                phase_mode = 1'b1;
            end else begin
                phase_mode = $urandom_range(0, 1);
            end
            set_mode(phase_mode);
            // fill the block against a stalled receiver in this phase
            if (ph == 2) begin
                hold_req <= 1'b1;
            end
            // last phase runs at full rate on both sides
            if (ph == RAND_PHASES - 1) begin
                calm <= 1'b1;
            end
            for (idx = 0; idx < PHASE_ITEMS; idx++) begin
                send_group(random_group());
                sender_gap();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off on request, steady at the end.
    initial begin : receiver
        int   hold_cnt;
        logic hold_done;

        hold_done = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) begin
                    @(posedge aclk);
                end
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

endmodule
